/* rtl/core/tprc_pkg.sv */
// Shared types and constants for the timer prescaler and reload calculator.
// Used by tprc_div and timer_prescaler_reload_calc_unit; depends on nothing.
`default_nettype none
package tprc_pkg;

  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned COUNT_W     = 30;
  localparam int unsigned DIVISOR_W   = 16;
  localparam int unsigned STEP_W      = $clog2(COUNT_W + 1);
  localparam int unsigned PRESCALER_W = 12;
  localparam int unsigned RELOAD_W    = 16;
  localparam int unsigned ODD_W       = 15;

  localparam logic [COUNT_W-1:0]     TICKS_PER_MS   = COUNT_W'(13560);
  localparam logic [DIVISOR_W-1:0]   RELOAD_LIMIT   = DIVISOR_W'(16'hFFFF);
  localparam logic [PRESCALER_W-1:0] PRESCALER_MAX  = PRESCALER_W'(12'hFFF);
  localparam logic [ODD_W-2:0]       PRESCALER_LAST = (ODD_W-1)'(12'hFFE);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_Q1_START,
    ST_Q1_WAIT,
    ST_ADJ,
    ST_Q2_START,
    ST_Q2_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

/* rtl/core/tprc_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tprc_pkg for widths and the status struct.
`default_nettype none
module tprc_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [tprc_pkg::COUNT_W-1:0]     dividend,
  input  wire logic [tprc_pkg::DIVISOR_W-1:0]   divisor,
  output logic      [tprc_pkg::COUNT_W-1:0]     quotient,
  output tprc_pkg::div_stat_t                   stat
);

  logic [tprc_pkg::DIVISOR_W-1:0] rem;
  logic [tprc_pkg::DIVISOR_W-1:0] dsr;
  logic [tprc_pkg::COUNT_W-1:0]   quo;
  logic [tprc_pkg::STEP_W-1:0]    step;
  logic                           busy;
  logic                           done;
  logic [tprc_pkg::DIVISOR_W:0]   trial;
  logic [tprc_pkg::DIVISOR_W:0]   diff;
  logic                           ge;

  // The partial remainder stays below the divisor, so one extra bit covers the shift.
  always_comb begin
    trial = {rem, quo[tprc_pkg::COUNT_W-1]};
    diff  = trial - {1'b0, dsr};
    ge    = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == tprc_pkg::STEP_W'(1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dsr  <= divisor;
      step <= tprc_pkg::STEP_W'(tprc_pkg::COUNT_W);
    end else if (busy) begin
      rem  <= ge ? diff[tprc_pkg::DIVISOR_W-1:0] : trial[tprc_pkg::DIVISOR_W-1:0];
      quo  <= {quo[tprc_pkg::COUNT_W-2:0], ge};
      step <= step - tprc_pkg::STEP_W'(1);
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

/* rtl/core/timer_prescaler_reload_calc_unit.sv */
// Timer prescaler and reload calculator; uses tprc_pkg and tprc_div.
// The sequencer forms the tick count, then makes two passes through the shared bit-serial divider
// before the result is loaded into the output register; saturated results skip the second pass,
// and a zero delay skips both passes.
// A new transaction is taken only once the sequencer is idle again; the next input is taken while a result waits.
// Reset (rst, synchronous, active high) empties the output register and idles the sequencer.
`default_nettype none
module timer_prescaler_reload_calc_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [tprc_pkg::DELAY_W-1:0]        delay_ms,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [tprc_pkg::PRESCALER_W-1:0]    prescaler,
  output logic      [tprc_pkg::RELOAD_W-1:0]       reload,
  output logic                                     range_error
);

  // The sequencer works as follows. An accepted delay is multiplied by the tick rate
  // and one is taken off to form the tick count. The divider then finds
  // count / 65535; one more, rounded up to odd, is the smallest divisor that brings
  // the reload below 65535. A second divider pass gives count / divisor as the reload.
  // A zero delay skips both passes, and a divisor whose prescaler lies above 4094 skips
  // the second; in either case the result is saturated with the range error flag set.

  tprc_pkg::state_t state;
  tprc_pkg::state_t state_next;

  logic [tprc_pkg::DELAY_W-1:0]     delay;
  logic                             zero;
  logic [tprc_pkg::COUNT_W-1:0]     count;
  logic [tprc_pkg::ODD_W-1:0]       divsr;
  logic [tprc_pkg::PRESCALER_W-1:0] presc;
  logic                             err;

  logic                             div_start;
  logic [tprc_pkg::DIVISOR_W-1:0]   div_divisor;
  logic [tprc_pkg::COUNT_W-1:0]     div_quotient;
  tprc_pkg::div_stat_t              div_stat;

  logic                             accept;
  logic                             out_load;
  logic [tprc_pkg::ODD_W-1:0]       q1;
  logic [tprc_pkg::ODD_W-1:0]       odd_div;
  logic [tprc_pkg::ODD_W-2:0]       p_wide;

  // First quotient is at most 13560, so fifteen bits leave room for the odd round-up.
  always_comb begin
    q1      = div_quotient[tprc_pkg::ODD_W-1:0];
    odd_div = q1[0] ? (q1 + tprc_pkg::ODD_W'(2)) : (q1 + tprc_pkg::ODD_W'(1));
    p_wide  = odd_div[tprc_pkg::ODD_W-1:1];
  end

  // The divisor is the constant limit on the first pass and the odd divisor on the second.
  assign div_divisor = (state == tprc_pkg::ST_Q1_START) ? tprc_pkg::RELOAD_LIMIT
                                                       : tprc_pkg::DIVISOR_W'(divsr);

  tprc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (count),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      tprc_pkg::ST_IDLE: begin
        if (in_valid) state_next = tprc_pkg::ST_MUL;
      end
      tprc_pkg::ST_MUL: begin
        state_next = zero ? tprc_pkg::ST_DONE : tprc_pkg::ST_Q1_START;
      end
      tprc_pkg::ST_Q1_START: state_next = tprc_pkg::ST_Q1_WAIT;
      tprc_pkg::ST_Q1_WAIT: begin
        if (div_stat.done) state_next = tprc_pkg::ST_ADJ;
      end
      tprc_pkg::ST_ADJ: begin
        state_next = (p_wide > tprc_pkg::PRESCALER_LAST) ? tprc_pkg::ST_DONE
                                                          : tprc_pkg::ST_Q2_START;
      end
      tprc_pkg::ST_Q2_START: state_next = tprc_pkg::ST_Q2_WAIT;
      tprc_pkg::ST_Q2_WAIT: begin
        if (div_stat.done) state_next = tprc_pkg::ST_DONE;
      end
      tprc_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = tprc_pkg::ST_IDLE;
      end
      default: state_next = tprc_pkg::ST_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_stall  = (state != tprc_pkg::ST_IDLE);
    div_start = (state == tprc_pkg::ST_Q1_START) || (state == tprc_pkg::ST_Q2_START);
    out_load  = (state == tprc_pkg::ST_DONE) && (!out_valid || !out_stall);
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tprc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers; they need no reset since the sequencer qualifies every use.
  always_ff @(posedge clk) begin
    if (accept) begin
      delay <= delay_ms;
      zero  <= (delay_ms == '0);
    end
    if (state == tprc_pkg::ST_MUL) begin
      count <= (tprc_pkg::COUNT_W'(delay) * tprc_pkg::TICKS_PER_MS)
               - tprc_pkg::COUNT_W'(1);
      err   <= zero;
    end
    if (state == tprc_pkg::ST_ADJ) begin
      divsr <= odd_div;
      presc <= p_wide[tprc_pkg::PRESCALER_W-1:0];
      err   <= (p_wide > tprc_pkg::PRESCALER_LAST);
    end
    if (out_load) begin
      prescaler   <= err ? tprc_pkg::PRESCALER_MAX : presc;
      reload      <= err ? tprc_pkg::RELOAD_LIMIT
                         : div_quotient[tprc_pkg::RELOAD_W-1:0];
      range_error <= err;
    end
  end

endmodule
`default_nettype wire
